FILE: hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants of the bucketed priority scheduler
// Bucket boundaries, request and status codes, the queued item format and the
// state encoding of the execution engine.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int NUM_BUCKETS   = 62;
  localparam int BKT_W         = 6;
  localparam int FIELD_W       = 64;
  localparam int TOTAL_W       = 10;
  localparam int LIMIT_W       = 12;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd992;

  // Division by the bucket count: floor(x * RECIP / 2^RECIP_SHIFT) equals
  // floor(x / NUM_BUCKETS) for every 12-bit x.
  localparam int RECIP_W     = 15;
  localparam int PROD_W      = LIMIT_W + RECIP_W;
  localparam int RECIP_SHIFT = 20;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = 15'd16913;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  typedef logic [NUM_BUCKETS-1:0][FIELD_W-1:0] min_tbl_t;

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] etime;
    logic [FIELD_W-1:0] ehash;
    logic [BKT_W-1:0]   bucket;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_FILL,
    BK_SRD,
    BK_SCMP,
    BK_DEC,
    BK_MRD,
    BK_MWR,
    BK_INS,
    BK_POPH,
    BK_PRD,
    BK_PWR,
    BK_FIN,
    BK_SEEK,
    BK_DONE
  } bk_state_t;

  // Sub-region counts of the eight geometric regions, as powers of two.
  localparam int PART_LOG2 [8] = '{1, 2, 3, 4, 4, 3, 2, 1};

  function automatic min_tbl_t build_min();
    min_tbl_t           tbl;
    int                 k;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] width;
    tbl = '0;
    k = 1;
    for (int r = 0; r < 8; r++) begin
      base  = 64'd1 << (24 + 4 * r);
      width = (base * 64'd15) >> PART_LOG2[r];
      for (int i = 0; i < (1 << PART_LOG2[r]); i++) begin
        if (k < NUM_BUCKETS) begin
          tbl[k] = base + 64'(i) * width;
          k++;
        end
      end
    end
    if (k < NUM_BUCKETS) begin
      tbl[k] = 64'd1 << 56;
    end
    return tbl;
  endfunction

  localparam min_tbl_t BUCKET_MIN = build_min();

  function automatic logic [BKT_W-1:0] next_bucket(input logic [BKT_W-1:0] b);
    logic [BKT_W-1:0] n;
    if (b == BKT_W'(NUM_BUCKETS - 1)) begin
      n = '0;
    end else begin
      n = b + BKT_W'(1);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/bps_front.sv
// ----------------------------------------------------------------------------
// bps_front: request intake and bucket classification
// Registers each accepted item together with the bucket chosen by the upper
// half of its balance, and hands it to the queue.
// ----------------------------------------------------------------------------
module bps_front import bps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [FIELD_W-1:0] in_entry_time,
  input  logic [FIELD_W-1:0] in_entry_hash,
  input  logic [FIELD_W-1:0] in_balance_hi,
  output logic               q_wr_valid,
  input  logic               q_wr_ready,
  output item_t              q_wr_item
);

  logic                   stg_valid_r, stg_valid_nxt;
  item_t                  stg_item_r;
  logic [NUM_BUCKETS-1:0] ge;
  logic [NUM_BUCKETS-1:0] ge_up;
  logic [BKT_W-1:0]       bkt;
  logic                   take;

  // The boundaries ascend, so the compares form a thermometer code and the
  // bucket is the position of its last set bit.
  always_comb begin
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      ge[i] = (in_balance_hi >= BUCKET_MIN[i]);
    end
    ge_up = {1'b0, ge[NUM_BUCKETS-1:1]};
    bkt = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (ge[i] && !ge_up[i]) begin
        bkt = bkt | BKT_W'(i);
      end
    end
  end

  assign in_stall   = stg_valid_r && !q_wr_ready;
  assign take       = in_valid && !in_stall;
  assign q_wr_valid = stg_valid_r;
  assign q_wr_item  = stg_item_r;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (take) begin
      stg_valid_nxt = 1'b1;
    end else if (q_wr_ready) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_item_r.op     <= in_req_type;
      stg_item_r.etime  <= in_entry_time;
      stg_item_r.ehash  <= in_entry_hash;
      stg_item_r.bucket <= bkt;
    end
  end

endmodule

FILE: hw/rtl/bps_queue.sv
// ----------------------------------------------------------------------------
// bps_queue: short item queue
// Decouples classification from execution so either side may stall alone.
// ----------------------------------------------------------------------------
module bps_queue import bps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_pop,
  output item_t rd_item
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  assign wr_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

endmodule

FILE: hw/rtl/bps_back.sv
// ----------------------------------------------------------------------------
// bps_back: execution engine
// Holds the bucket slot memory and fill counts, performs sorted insert, pop
// and round-robin seek one slot or one bucket per step, and registers results.
// ----------------------------------------------------------------------------
module bps_back import bps_pkg::*; #(
  parameter int BUCKET_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [BKT_W-1:0]   out_bucket_index,
  output logic [FIELD_W-1:0] out_time,
  output logic [FIELD_W-1:0] out_hash,
  output logic               out_trimmed,
  output logic               out_duplicate,
  output logic               out_is_empty,
  output logic [TOTAL_W-1:0] out_total_count,
  output logic [BKT_W-1:0]   out_current_bucket
);

  localparam int SLOTS  = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int TOT_W  = $clog2(SLOTS + 1);
  localparam int SLOT_W = 2 * FIELD_W;

  bk_state_t state_r, state_nxt;

  logic [SLOT_W-1:0]      slot_mem [SLOTS];
  logic [FILL_W-1:0]      fill_mem [NUM_BUCKETS];
  logic [SLOT_W-1:0]      rd_q_r;
  logic [FILL_W-1:0]      fill_q_r;

  logic [LIMIT_W-1:0]     limit_r, limit_nxt;
  logic [FILL_W-1:0]      cap_r, cap_nxt;
  logic [PROD_W-1:0]      prod;
  logic [QUO_W-1:0]       quo;

  logic                   op_r, op_nxt;
  logic [FIELD_W-1:0]     t_r, t_nxt;
  logic [FIELD_W-1:0]     h_r, h_nxt;
  logic [BKT_W-1:0]       b_r, b_nxt;
  logic [FILL_W-1:0]      n_r, n_nxt;
  logic [FILL_W-1:0]      p_r, p_nxt;
  logic [FILL_W-1:0]      j_r, j_nxt;
  logic                   dup_r, dup_nxt;
  logic                   trim_r, trim_nxt;
  logic                   status_r, status_nxt;
  logic                   from_empty_r, from_empty_nxt;
  logic [FIELD_W-1:0]     ot_r, ot_nxt;
  logic [FIELD_W-1:0]     oh_r, oh_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [BKT_W-1:0]       rr_r, rr_nxt;
  logic [BKT_W-1:0]       seek_cnt_r, seek_cnt_nxt;
  logic [NUM_BUCKETS-1:0] nonempty_r, nonempty_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_status_r;
  logic [BKT_W-1:0]       out_bucket_r;
  logic [FIELD_W-1:0]     out_time_r;
  logic [FIELD_W-1:0]     out_hash_r;
  logic                   out_trim_r;
  logic                   out_dup_r;
  logic                   out_empty_r;
  logic [TOTAL_W-1:0]     out_total_r;
  logic [BKT_W-1:0]       out_rr_r;
  logic                   out_load;

  logic [FIELD_W-1:0]     rd_time;
  logic [FIELD_W-1:0]     rd_hash;
  logic                   slot_eq;
  logic                   slot_gt;
  logic [FILL_W-1:0]      fill_val;
  logic                   pop_refused;
  logic                   need_shift;
  logic [FILL_W-1:0]      shift_top;
  logic                   seek_more;
  logic                   do_seek;

  logic [BKT_W-1:0]       fill_raddr;
  logic                   fill_we;
  logic                   slot_we;
  logic [FILL_W-1:0]      ridx;
  logic [FILL_W-1:0]      widx;
  logic [ADDR_W-1:0]      slot_base;
  logic [ADDR_W-1:0]      slot_raddr;
  logic [ADDR_W-1:0]      slot_waddr;
  logic [SLOT_W-1:0]      slot_wdata;

  // Per-bucket cap: max(1, limit / NUM_BUCKETS), saturated at the depth.
  assign prod = PROD_W'(limit_r) * PROD_W'(RECIP);
  assign quo  = prod[PROD_W-1:RECIP_SHIFT];

  always_comb begin
    if (int'(quo) > BUCKET_DEPTH) begin
      cap_nxt = FILL_W'(BUCKET_DEPTH);
    end else if (quo == '0) begin
      cap_nxt = FILL_W'(1);
    end else begin
      cap_nxt = FILL_W'(quo);
    end
    limit_nxt = cfg_wr_en ? cfg_wr_data : limit_r;
  end

  assign rd_time  = rd_q_r[SLOT_W-1:FIELD_W];
  assign rd_hash  = rd_q_r[FIELD_W-1:0];
  assign slot_eq  = (rd_time == t_r) && (rd_hash == h_r);
  assign slot_gt  = (rd_time > t_r) || ((rd_time == t_r) && (rd_hash > h_r));

  // A bucket whose nonempty bit is clear reads as empty even if never written.
  assign fill_val    = nonempty_r[b_r] ? fill_q_r : '0;
  assign pop_refused = (total_r == '0) || (fill_val == '0);

  // Slots to move when inserting: a full bucket drops its last slot.
  assign shift_top  = (n_r == FILL_W'(BUCKET_DEPTH)) ? n_r - FILL_W'(1) : n_r;
  assign need_shift = (shift_top > p_r);
  assign seek_more  = !nonempty_r[rr_r] && (seek_cnt_r < BKT_W'(NUM_BUCKETS));
  assign do_seek    = (op_r == OP_POP) || from_empty_r;
  assign out_load   = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = BK_FILL;
        end
      end
      BK_FILL: begin
        if (op_r == OP_POP) begin
          state_nxt = pop_refused ? BK_DONE : BK_POPH;
        end else begin
          state_nxt = (fill_val == '0) ? BK_DEC : BK_SRD;
        end
      end
      BK_SRD: state_nxt = BK_SCMP;
      BK_SCMP: begin
        if (slot_eq || slot_gt || (p_r + FILL_W'(1) == n_r)) begin
          state_nxt = BK_DEC;
        end else begin
          state_nxt = BK_SRD;
        end
      end
      BK_DEC: begin
        if (dup_r) begin
          state_nxt = BK_FIN;
        end else if (n_r == FILL_W'(BUCKET_DEPTH) && p_r == n_r) begin
          state_nxt = BK_FIN;
        end else begin
          state_nxt = need_shift ? BK_MRD : BK_INS;
        end
      end
      BK_MRD: state_nxt = BK_MWR;
      BK_MWR: begin
        state_nxt = (j_r - FILL_W'(1) == p_r) ? BK_INS : BK_MRD;
      end
      BK_INS: state_nxt = BK_FIN;
      BK_POPH: begin
        state_nxt = (n_r > FILL_W'(1)) ? BK_PRD : BK_FIN;
      end
      BK_PRD: state_nxt = BK_PWR;
      BK_PWR: begin
        state_nxt = (j_r == n_r) ? BK_FIN : BK_PRD;
      end
      BK_FIN: begin
        state_nxt = do_seek ? BK_SEEK : BK_DONE;
      end
      BK_SEEK: begin
        state_nxt = seek_more ? BK_SEEK : BK_DONE;
      end
      BK_DONE: begin
        if (out_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    op_nxt         = op_r;
    t_nxt          = t_r;
    h_nxt          = h_r;
    b_nxt          = b_r;
    n_nxt          = n_r;
    p_nxt          = p_r;
    j_nxt          = j_r;
    dup_nxt        = dup_r;
    trim_nxt       = trim_r;
    status_nxt     = status_r;
    from_empty_nxt = from_empty_r;
    ot_nxt         = ot_r;
    oh_nxt         = oh_r;
    total_nxt      = total_r;
    rr_nxt         = rr_r;
    seek_cnt_nxt   = seek_cnt_r;
    nonempty_nxt   = nonempty_r;
    q_pop          = 1'b0;
    fill_raddr     = b_r;
    fill_we        = 1'b0;
    slot_we        = 1'b0;
    ridx           = p_r;
    widx           = j_r;
    slot_wdata     = rd_q_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          op_nxt         = q_item.op;
          t_nxt          = q_item.etime;
          h_nxt          = q_item.ehash;
          b_nxt          = (q_item.op == OP_POP) ? rr_r : q_item.bucket;
          fill_raddr     = b_nxt;
          dup_nxt        = 1'b0;
          trim_nxt       = 1'b0;
          status_nxt     = ST_OK;
          ot_nxt         = '0;
          oh_nxt         = '0;
          from_empty_nxt = (total_r == '0);
        end
      end
      BK_FILL: begin
        n_nxt = fill_val;
        p_nxt = '0;
        ridx  = '0;
        if (op_r == OP_POP && pop_refused) begin
          status_nxt = ST_EMPTY;
        end
      end
      BK_SRD: begin
        ridx = p_r;
      end
      BK_SCMP: begin
        if (slot_eq) begin
          dup_nxt = 1'b1;
        end else if (!slot_gt) begin
          p_nxt = p_r + FILL_W'(1);
        end
      end
      BK_DEC: begin
        j_nxt = shift_top;
        if (dup_r) begin
          if (n_r > cap_r) begin
            n_nxt     = n_r - FILL_W'(1);
            total_nxt = total_r - TOT_W'(1);
            trim_nxt  = 1'b1;
          end
        end else if (n_r < FILL_W'(BUCKET_DEPTH)) begin
          // The insert happens; if it lands above the cap the last slot goes.
          if (n_r >= cap_r) begin
            trim_nxt = 1'b1;
          end else begin
            n_nxt     = n_r + FILL_W'(1);
            total_nxt = total_r + TOT_W'(1);
          end
        end else begin
          trim_nxt = 1'b1;
        end
      end
      BK_MRD: begin
        ridx = j_r - FILL_W'(1);
      end
      BK_MWR: begin
        slot_we = 1'b1;
        widx    = j_r;
        j_nxt   = j_r - FILL_W'(1);
      end
      BK_INS: begin
        slot_we    = 1'b1;
        widx       = p_r;
        slot_wdata = {t_r, h_r};
      end
      BK_POPH: begin
        ot_nxt    = rd_time;
        oh_nxt    = rd_hash;
        n_nxt     = n_r - FILL_W'(1);
        total_nxt = total_r - TOT_W'(1);
        j_nxt     = FILL_W'(1);
      end
      BK_PRD: begin
        ridx = j_r;
      end
      BK_PWR: begin
        slot_we = 1'b1;
        widx    = j_r - FILL_W'(1);
        j_nxt   = j_r + FILL_W'(1);
      end
      BK_FIN: begin
        fill_we           = 1'b1;
        nonempty_nxt[b_r] = (n_r != '0);
        if (do_seek) begin
          rr_nxt       = next_bucket(rr_r);
          seek_cnt_nxt = '0;
        end
      end
      BK_SEEK: begin
        if (seek_more) begin
          rr_nxt       = next_bucket(rr_r);
          seek_cnt_nxt = seek_cnt_r + BKT_W'(1);
        end
      end
      BK_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign slot_base  = ADDR_W'(ADDR_W'(b_r) * ADDR_W'(BUCKET_DEPTH));
  assign slot_raddr = ADDR_W'(slot_base + ADDR_W'(ridx));
  assign slot_waddr = ADDR_W'(slot_base + ADDR_W'(widx));

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    rd_q_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[b_r] <= n_r;
    end
    fill_q_r <= fill_mem[fill_raddr];
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == BK_DONE && out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      limit_r     <= LIMIT_RESET;
      total_r     <= '0;
      rr_r        <= '0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      total_r     <= total_nxt;
      rr_r        <= rr_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r        <= cap_nxt;
    op_r         <= op_nxt;
    t_r          <= t_nxt;
    h_r          <= h_nxt;
    b_r          <= b_nxt;
    n_r          <= n_nxt;
    p_r          <= p_nxt;
    j_r          <= j_nxt;
    dup_r        <= dup_nxt;
    trim_r       <= trim_nxt;
    status_r     <= status_nxt;
    from_empty_r <= from_empty_nxt;
    ot_r         <= ot_nxt;
    oh_r         <= oh_nxt;
    seek_cnt_r   <= seek_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_DONE && out_load) begin
      out_status_r <= status_r;
      out_bucket_r <= b_r;
      out_time_r   <= ot_r;
      out_hash_r   <= oh_r;
      out_trim_r   <= trim_r;
      out_dup_r    <= dup_r;
      out_empty_r  <= (total_r == '0);
      out_total_r  <= TOTAL_W'(total_r);
      out_rr_r     <= rr_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_bucket_index   = out_bucket_r;
  assign out_time           = out_time_r;
  assign out_hash           = out_hash_r;
  assign out_trimmed        = out_trim_r;
  assign out_duplicate      = out_dup_r;
  assign out_is_empty       = out_empty_r;
  assign out_total_count    = out_total_r;
  assign out_current_bucket = out_rr_r;

  // Between items the entry count and the nonempty map must agree.
  a_empty_map: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE) |-> ((total_r == '0) == (nonempty_r == '0)))
    else $error("entry count disagrees with nonempty map");

  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_POPH) |-> (n_r != '0))
    else $error("head taken from an empty bucket");

  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MWR) |-> (j_r > p_r))
    else $error("insert shift passed the insert point");

  a_seek_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SEEK) |-> (seek_cnt_r <= BKT_W'(NUM_BUCKETS)))
    else $error("seek ran past one full turn");

endmodule

FILE: hw/rtl/bucketed_priority_scheduler.sv
// ----------------------------------------------------------------------------
// bucketed_priority_scheduler: sorted buckets with round-robin service
// Items are classified into one of 62 buckets and queued; an engine keeps each
// bucket sorted by (time, hash) and serves the buckets in turn.
// ----------------------------------------------------------------------------
// Items are processed one at a time by the engine, which works through a
// slot memory with one read and one write port. A push reads the fill count,
// compares slots up to the insert point, moves the slots behind it and writes
// the entry; a push into an empty store then seeks the next nonempty bucket at
// one bucket per cycle. A pop takes the head of its bucket, moves each entry
// left in the bucket up by one slot and then seeks, and a pop refused on an
// empty store goes straight to its result. The final state of an item holds
// while the previous result still waits at the output. The front accepts and
// classifies up to three items ahead of the engine, and a finished result
// waits in an output register without holding the engine's intake.
// The user must write total_limit through cfg_wr_en and cfg_wr_data only while
// the block is idle; the block itself does not enforce it.
module bucketed_priority_scheduler import bps_pkg::*; #(
  parameter int BUCKET_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [FIELD_W-1:0] in_entry_time,
  input  logic [FIELD_W-1:0] in_entry_hash,
  input  logic [FIELD_W-1:0] in_balance_hi,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [BKT_W-1:0]   out_bucket_index,
  output logic [FIELD_W-1:0] out_time,
  output logic [FIELD_W-1:0] out_hash,
  output logic               out_trimmed,
  output logic               out_duplicate,
  output logic               out_is_empty,
  output logic [TOTAL_W-1:0] out_total_count,
  output logic [BKT_W-1:0]   out_current_bucket,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  logic  fq_valid;
  logic  fq_ready;
  item_t fq_item;
  logic  qb_valid;
  logic  qb_pop;
  item_t qb_item;

  bps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_entry_time (in_entry_time),
    .in_entry_hash (in_entry_hash),
    .in_balance_hi (in_balance_hi),
    .q_wr_valid    (fq_valid),
    .q_wr_ready    (fq_ready),
    .q_wr_item     (fq_item)
  );

  bps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_pop   (qb_pop),
    .rd_item  (qb_item)
  );

  bps_back #(
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (qb_valid),
    .q_item             (qb_item),
    .q_pop              (qb_pop),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_bucket_index   (out_bucket_index),
    .out_time           (out_time),
    .out_hash           (out_hash),
    .out_trimmed        (out_trimmed),
    .out_duplicate      (out_duplicate),
    .out_is_empty       (out_is_empty),
    .out_total_count    (out_total_count),
    .out_current_bucket (out_current_bucket)
  );

endmodule
